/* hw/rtl/tvc_pkg.sv */
package tvc_pkg;

	localparam int CHANNELS      = 8;
	localparam int VALUE_WIDTH   = 64;
	localparam int NREP          = 3;
	localparam int CH_W          = 3;
	localparam int REP_W         = 2;
	localparam int TICK_W        = 16;
	localparam int CIU_W         = 4;
	localparam int CFG_W         = 16;
	localparam int CFG_IDX_W     = 2;
	localparam int DEFAULT_TICKS = 120;

	typedef enum logic [1:0] {
		MODE_VOTE  = 2'd0,
		MODE_INPUT = 2'd1,
		MODE_TICK  = 2'd2
	} tvc_mode_t;

	typedef enum logic [1:0] {
		KIND_MAJORITY  = 2'd0,
		KIND_NO_AGREE  = 2'd1,
		KIND_DUPLICATE = 2'd2,
		KIND_RESTART   = 2'd3
	} tvc_kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TIMEOUT_TICKS   = 2'd0,
		CFG_START_CHANNEL   = 2'd1,
		CFG_STOP_CHANNEL    = 2'd2,
		CFG_CHANNELS_IN_USE = 2'd3
	} tvc_cfg_idx_t;

	typedef enum logic [1:0] {
		MERGE_KEEP = 2'd0,
		MERGE_SET  = 2'd1,
		MERGE_COPY = 2'd2
	} tvc_merge_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_READ    = 3'd1,
		ST_MERGE   = 3'd2,
		ST_DUP     = 3'd3,
		ST_CHECK   = 3'd4,
		ST_RESTART = 3'd5,
		ST_FLUSH   = 3'd6
	} tvc_state_t;

	typedef enum logic [1:0] {
		JOB_VOTE = 2'd0,
		JOB_STOP = 2'd1,
		JOB_WALK = 2'd2
	} tvc_job_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [1:0]  replica;
		logic [2:0]  channel;
		logic [63:0] value;
	} tvc_in_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [2:0]  out_channel;
		logic [63:0] majority_value;
		logic        corruption_seen;
		logic [1:0]  faulty_replica;
		logic        last;
	} tvc_out_t;

	typedef logic [NREP-1:0][VALUE_WIDTH-1:0] tvc_row_t;

	typedef struct packed {
		logic                   rd;
		logic                   merge;
		tvc_merge_t             op;
		logic                   sdc;
		logic [CH_W-1:0]        addr;
		logic [REP_W-1:0]       rep;
		logic [REP_W-1:0]       src;
		logic [VALUE_WIDTH-1:0] value;
	} tvc_row_req_t;

	typedef struct packed {
		logic                   agree;
		logic                   corrupt;
		logic [REP_W-1:0]       faulty;
		logic [VALUE_WIDTH-1:0] value;
	} tvc_chk_t;

	typedef struct packed {
		logic arm;
		logic tick;
		logic clear;
	} tvc_tmr_cmd_t;

	function automatic logic ch_ok(input logic [CH_W-1:0] ch);
		return int'(ch) < CHANNELS;
	endfunction

	function automatic logic [REP_W-1:0] rep_src(input logic [REP_W-1:0] r);
		logic [REP_W-1:0] s;
		case (r)
			2'd0: s = 2'd2;
			2'd1: s = 2'd0;
			default: s = 2'd1;
		endcase
		return s;
	endfunction

endpackage

/* hw/rtl/tvc_row_store.sv */
module tvc_row_store (
	input  logic                 clk,
	input  tvc_pkg::tvc_row_req_t req,
	output tvc_pkg::tvc_chk_t     chk
);
	import tvc_pkg::*;

	tvc_row_t mem [CHANNELS];
	tvc_row_t rd_s1;
	tvc_row_t merged;
	tvc_chk_t chk_s1;
	tvc_chk_t chk_next;
	logic     eq01, eq12, eq20;

	always_ff @(posedge clk) begin
		if (req.rd) begin
			rd_s1 <= mem[req.addr];
		end
	end

	always_comb begin
		merged = rd_s1;
		case (req.op)
			MERGE_SET:  merged[req.rep] = req.value;
			MERGE_COPY: merged[req.rep] = rd_s1[req.src];
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (req.merge && req.op != MERGE_KEEP) begin
			mem[req.addr] <= merged;
		end
	end

	assign eq01 = merged[0] == merged[1];
	assign eq12 = merged[1] == merged[2];
	assign eq20 = merged[2] == merged[0];

	always_comb begin
		chk_next.agree = eq01 || eq12 || eq20;
		if (eq01) begin
			chk_next.value   = merged[0];
			chk_next.corrupt = req.sdc && !eq20;
			chk_next.faulty  = 2'd2;
		end else if (eq12) begin
			chk_next.value   = merged[1];
			chk_next.corrupt = req.sdc;
			chk_next.faulty  = 2'd0;
		end else begin
			chk_next.value   = merged[2];
			chk_next.corrupt = req.sdc && eq20;
			chk_next.faulty  = 2'd1;
		end
		if (!chk_next.corrupt) begin
			chk_next.faulty = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.merge) begin
			chk_s1 <= chk_next;
		end
	end

	assign chk = chk_s1;

endmodule

/* hw/rtl/tvc_timer.sv */
module tvc_timer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tvc_pkg::tvc_tmr_cmd_t         cmd,
	input  logic [tvc_pkg::TICK_W-1:0]    timeout_ticks,
	output logic                          expire
);
	import tvc_pkg::*;

	logic              started_q;
	logic              armed_q;
	logic [TICK_W-1:0] count_q;
	logic [TICK_W-1:0] count_dec;

	assign count_dec = (count_q != '0) ? count_q - TICK_W'(1) : '0;
	assign expire    = cmd.tick && armed_q && (count_dec == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			armed_q   <= 1'b0;
			count_q   <= '0;
		end else if (cmd.clear) begin
			started_q <= 1'b0;
			armed_q   <= 1'b0;
			count_q   <= '0;
		end else if (cmd.arm && !started_q) begin
			started_q <= 1'b1;
			armed_q   <= 1'b1;
			count_q   <= (timeout_ticks != '0) ? timeout_ticks : TICK_W'(DEFAULT_TICKS);
		end else if (cmd.tick && armed_q) begin
			count_q <= count_dec;
			if (count_dec == '0) begin
				armed_q <= 1'b0;
			end
		end
	end

`ifndef SYNTH
	a_expire_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		expire |=> !armed_q)
		else $error("timer still armed after expiry");
`endif

endmodule

/* hw/rtl/tmr_vote_collector.sv */
// channel | direction | handshake              | word
// config  | in        | cfg_we (no wait)       | cfg_index, cfg_data
// vote    | in        | vote_valid/vote_ready  | vote_word (mode, replica, channel, value)
// result  | out       | res_valid/res_ready    | res_word (kind, channel, value, flags, last)
// A vote passes through accept with row read, merge and write back, duplicate report,
// check, and release of the final word; report, check and release can wait for the output.
// Timeout expiry: merge, check, restart, then read, merge, check per channel in use; release.
// Reset clears marks and timer, loads default config at once; the value memory is not cleared.
// A word held at the output stalls the sequencer at its next result; votes are taken only
// when the sequencer is idle.
module tmr_vote_collector (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tvc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tvc_pkg::CFG_W-1:0]      cfg_data,
	input  logic                           vote_valid,
	output logic                           vote_ready,
	input  tvc_pkg::tvc_in_t               vote_word,
	output logic                           res_valid,
	input  logic                           res_ready,
	output tvc_pkg::tvc_out_t              res_word
);
	import tvc_pkg::*;

	logic [TICK_W-1:0] timeout_ticks_q;
	logic [CH_W-1:0]   start_channel_q;
	logic [CH_W-1:0]   stop_channel_q;
	logic [CIU_W-1:0]  channels_in_use_q;
	logic [CIU_W-1:0]  lim;

	tvc_state_t             state_q, state_next;
	tvc_job_t               job_q;
	logic [CH_W-1:0]        addr_q;
	logic [REP_W-1:0]       rep_q;
	logic [VALUE_WIDTH-1:0] value_q;
	logic                   dup_q;
	logic [NREP-1:0]        marks_q [CHANNELS];

	tvc_out_t pend_q, res_q, emit_word, push_word;
	logic     pend_valid_q, res_valid_q;

	tvc_row_req_t row_req;
	tvc_chk_t     chk;
	tvc_tmr_cmd_t tmr_cmd;
	logic         tmr_expire;

	logic             accept, vote_go, expire_go, miss_any, has_res, last_walk;
	logic             out_free, emit_ok, emit, push;
	logic [NREP-1:0]  stop_marks;
	logic [REP_W-1:0] miss_rep;

	tvc_row_store u_rows (
		.clk (clk),
		.req (row_req),
		.chk (chk)
	);

	tvc_timer u_timer (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (tmr_cmd),
		.timeout_ticks (timeout_ticks_q),
		.expire        (tmr_expire)
	);

	assign lim = (channels_in_use_q > CIU_W'(CHANNELS)) ? CIU_W'(CHANNELS) : channels_in_use_q;

	assign vote_ready = state_q == ST_IDLE;
	assign accept     = vote_valid && vote_ready;
	assign vote_go    = accept && vote_word.mode == MODE_VOTE
		&& vote_word.replica < REP_W'(NREP) && ch_ok(vote_word.channel);

	assign stop_marks = marks_q[stop_channel_q];
	assign miss_any   = stop_marks != '1;
	assign miss_rep   = !stop_marks[0] ? 2'd0 : (!stop_marks[1] ? 2'd1 : 2'd2);
	assign expire_go  = accept && vote_word.mode == MODE_TICK && tmr_expire
		&& ch_ok(stop_channel_q) && miss_any;

	assign has_res   = marks_q[addr_q] == '1;
	assign last_walk = (CIU_W'(addr_q) + CIU_W'(1)) >= lim;
	assign out_free  = !res_valid_q || res_ready;
	assign emit_ok   = !pend_valid_q || out_free;

	always_comb begin
		tmr_cmd       = '0;
		tmr_cmd.arm   = accept && vote_word.mode == MODE_INPUT && ch_ok(vote_word.channel)
			&& vote_word.channel == start_channel_q;
		tmr_cmd.tick  = accept && vote_word.mode == MODE_TICK;
		tmr_cmd.clear = state_q == ST_CHECK && has_res && emit_ok && addr_q == stop_channel_q;
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (vote_go || expire_go) begin
					state_next = ST_MERGE;
				end
			end
			ST_READ:  state_next = ST_MERGE;
			ST_MERGE: state_next = (job_q == JOB_VOTE) ? ST_DUP : ST_CHECK;
			ST_DUP: begin
				if (!dup_q || emit_ok) begin
					state_next = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!has_res || emit_ok) begin
					case (job_q)
						JOB_STOP: state_next = ST_RESTART;
						JOB_WALK: state_next = last_walk ? ST_FLUSH : ST_READ;
						default:  state_next = ST_FLUSH;
					endcase
				end
			end
			ST_RESTART: begin
				if (emit_ok) begin
					state_next = (lim == '0) ? ST_FLUSH : ST_READ;
				end
			end
			ST_FLUSH: begin
				if (!pend_valid_q || out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	always_comb begin
		row_req       = '0;
		row_req.addr  = addr_q;
		row_req.rep   = rep_q;
		row_req.src   = rep_src(rep_q);
		row_req.value = value_q;
		row_req.sdc   = job_q == JOB_VOTE;
		case (job_q)
			JOB_VOTE: row_req.op = MERGE_SET;
			JOB_WALK: row_req.op = MERGE_COPY;
			default:  row_req.op = MERGE_KEEP;
		endcase
		emit                      = 1'b0;
		emit_word                 = '0;
		emit_word.out_channel     = addr_q;
		case (state_q)
			ST_IDLE: begin
				row_req.rd   = vote_go || expire_go;
				row_req.addr = vote_go ? vote_word.channel : stop_channel_q;
			end
			ST_READ:  row_req.rd = 1'b1;
			ST_MERGE: row_req.merge = 1'b1;
			ST_DUP: begin
				emit           = dup_q;
				emit_word.kind = KIND_DUPLICATE;
			end
			ST_CHECK: begin
				emit = has_res;
				if (chk.agree) begin
					emit_word.kind            = KIND_MAJORITY;
					emit_word.majority_value  = 64'(chk.value);
					emit_word.corruption_seen = chk.corrupt;
					emit_word.faulty_replica  = chk.faulty;
				end else begin
					emit_word.kind = KIND_NO_AGREE;
				end
			end
			ST_RESTART: begin
				emit                     = 1'b1;
				emit_word.kind           = KIND_RESTART;
				emit_word.faulty_replica = rep_q;
			end
			default: ;
		endcase
	end

	assign push = (emit && emit_ok && pend_valid_q)
		|| (state_q == ST_FLUSH && pend_valid_q && out_free);

	always_comb begin
		push_word      = pend_q;
		push_word.last = state_q == ST_FLUSH;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_ticks_q   <= TICK_W'(DEFAULT_TICKS);
			start_channel_q   <= CH_W'(0);
			stop_channel_q    <= CH_W'(1);
			channels_in_use_q <= CIU_W'(CHANNELS);
		end else if (cfg_we) begin
			case (tvc_cfg_idx_t'(cfg_index))
				CFG_TIMEOUT_TICKS:   timeout_ticks_q   <= cfg_data[TICK_W-1:0];
				CFG_START_CHANNEL:   start_channel_q   <= cfg_data[CH_W-1:0];
				CFG_STOP_CHANNEL:    stop_channel_q    <= cfg_data[CH_W-1:0];
				CFG_CHANNELS_IN_USE: channels_in_use_q <= cfg_data[CIU_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q <= JOB_VOTE;
			dup_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				marks_q[c] <= '0;
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (vote_go) begin
						job_q <= JOB_VOTE;
					end else if (expire_go) begin
						job_q <= JOB_STOP;
						marks_q[stop_channel_q][miss_rep] <= 1'b1;
					end
				end
				ST_MERGE: begin
					if (job_q == JOB_VOTE) begin
						dup_q <= marks_q[addr_q][rep_q];
						marks_q[addr_q][rep_q] <= 1'b1;
					end else if (job_q == JOB_WALK) begin
						marks_q[addr_q][rep_q] <= marks_q[addr_q][rep_src(rep_q)];
					end
				end
				ST_CHECK: begin
					if (has_res && emit_ok && chk.agree) begin
						marks_q[addr_q] <= '0;
					end
				end
				ST_RESTART: begin
					if (emit_ok) begin
						job_q <= JOB_WALK;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (vote_go) begin
					addr_q  <= vote_word.channel;
					rep_q   <= vote_word.replica;
					value_q <= vote_word.value[VALUE_WIDTH-1:0];
				end else if (expire_go) begin
					addr_q <= stop_channel_q;
					rep_q  <= miss_rep;
				end
			end
			ST_CHECK: begin
				if ((!has_res || emit_ok) && job_q == JOB_WALK && !last_walk) begin
					addr_q <= addr_q + CH_W'(1);
				end
			end
			ST_RESTART: begin
				if (emit_ok) begin
					addr_q <= '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (emit && emit_ok) begin
				pend_valid_q <= 1'b1;
			end else if (state_q == ST_FLUSH && push) begin
				pend_valid_q <= 1'b0;
			end
			if (push) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit && emit_ok) begin
			pend_q <= emit_word;
		end
		if (push) begin
			res_q <= push_word;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_q;

`ifndef SYNTH
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_valid_q)
		else $error("result word left pending after item end");
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && push) |=> (res_valid && res_word.last))
		else $error("final word of an item not marked last");
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> (job_q == JOB_WALK && CIU_W'(addr_q) < lim))
		else $error("channel walk beyond channels in use");
`endif

endmodule
